// ===== rtl/ebi_pkg.sv =====
`timescale 1ns / 1ps
package ebi_pkg;
    localparam int MaxPointsDef = 256;
    localparam int FracBitsDef  = 8;
    localparam int PosW   = 32;
    localparam int AttW   = 16;
    localparam int LevelW = 26;
    localparam int PeakW  = 25;
    localparam int CfgW   = 25;
    localparam int CountW = 9;
    localparam int SegW   = 8;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_PEAK        = 1'b1;
    localparam logic MODE_WRITE      = 1'b0;
    localparam logic MODE_QUERY      = 1'b1;

    typedef struct packed {
        logic            mode;
        logic [7:0]      point_index;
        logic [PosW-1:0] point_position;
        logic [AttW-1:0] point_attenuation;
        logic [PosW-1:0] sample_position;
    } in_item_t;

    typedef struct packed {
        logic signed [LevelW-1:0] envelope_level;
        logic [SegW-1:0]          segment_index;
    } out_item_t;
endpackage

// ===== rtl/ebi_div.sv =====
`timescale 1ns / 1ps
module ebi_div import ebi_pkg::*; #(
    parameter int NumW = 64,
    parameter int DenW = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic            busy,
    output logic [NumW-1:0] quot
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] q_reg, q_next;
    logic [DenW:0]   r_reg, r_next;
    logic [DenW-1:0] d_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [DenW:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        trial = {r_reg[DenW-1:0], q_reg[NumW-1]};
        if (start) begin
            q_next = num;
            r_next = '0;
            cnt_next = CntW'(NumW);
        end else if (cnt_reg != '0) begin
            // restoring step, one quotient bit a cycle
            q_next = {q_reg[NumW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end else begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= den;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule

// ===== rtl/ebi_table.sv =====
`timescale 1ns / 1ps
module ebi_table import ebi_pkg::*; #(
    parameter int MaxPoints = MaxPointsDef
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(MaxPoints)-1:0] waddr,
    input  logic [PosW+AttW-1:0]         wdata,
    input  logic [$clog2(MaxPoints)-1:0] raddr,
    output logic [PosW+AttW-1:0]         rdata
);
    logic [PosW+AttW-1:0] mem [MaxPoints];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/envelope_breakpoint_interpolator_core.sv =====
`timescale 1ns / 1ps
// channel | ports            | payload
// in      | s_valid/s_ready  | in_item_t  s_item
// result  | m_valid/m_ready  | out_item_t m_item
// cfg     | cfg_we/cfg_index | cfg_wdata
// A write item is taken in S_IDLE. A query tests one segment with S_RD and S_CMP
// for the current and then the next point (two reads through the single read port
// of the breakpoint memory), over at most two passes, then a registered multiply and
// a serial divide. A query with no points gives its result in the cycle after accept.
// Reset is synchronous; the table is not cleared. A stalled result holds in
// the output register; the next item is accepted once the result is taken.
module envelope_breakpoint_interpolator_core import ebi_pkg::*; #(
    parameter int MaxPoints = MaxPointsDef,
    parameter int FracBits  = FracBitsDef
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CfgW-1:0]  cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item
);
    localparam int AW = $clog2(MaxPoints);
    localparam int NW = 64;
    localparam int CW = $clog2(MaxPoints + 1);
    localparam int AQW = AttW + FracBits + 3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD    = 8'b00000010,
        S_CMP   = 8'b00000100,
        S_LAST  = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_FIN   = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_MUL   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [CountW-1:0] count_reg;
    logic signed [PeakW-1:0] peak_reg;
    logic [SegW-1:0] last_seg_reg;
    logic [CW-1:0] n_eff;
    logic [AW-1:0] cur_reg, cur_next;
    logic pass_reg, pass_next;
    logic phase_reg, phase_next; // 0 = fetch cur, 1 = fetch next
    logic fb_reg;
    logic [PosW-1:0] s_reg;
    logic [PosW-1:0] p0_reg;
    logic [AttW-1:0] a0_reg;
    logic [PosW-1:0] len_reg;
    logic neg_reg;
    logic signed [AQW-1:0] attq_reg;
    logic [AW-1:0] raddr;
    logic [PosW+AttW-1:0] rdata;
    logic [PosW-1:0] rpos;
    logic [AttW-1:0] ratt;
    logic [NW-1:0] prod_reg, quot;
    logic div_start;
    logic div_busy;
    logic signed [LevelW+1:0] lvl;
    out_item_t m_item_reg;
    logic m_valid_reg;
    logic [SegW-1:0] seg_reg;
    logic [AttW:0] mag;

    assign n_eff = (count_reg > CountW'(MaxPoints)) ? CW'(MaxPoints) : CW'(count_reg);
    assign rpos = rdata[PosW+AttW-1:AttW];
    assign ratt = rdata[AttW-1:0];

    ebi_table #(.MaxPoints(MaxPoints)) u_table (
        .aclk(aclk),
        .we(s_valid && s_ready && s_item.mode == MODE_WRITE
            && 32'(s_item.point_index) < 32'(MaxPoints)),
        .waddr(AW'(s_item.point_index)),
        .wdata({s_item.point_position, s_item.point_attenuation}),
        .raddr(raddr),
        .rdata(rdata)
    );

    ebi_div #(.NumW(NW), .DenW(PosW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(prod_reg), .den(len_reg), .busy(div_busy), .quot(quot)
    );

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign mag = (ratt < a0_reg) ? {1'b0, a0_reg} - {1'b0, ratt}
                                 : {1'b0, ratt} - {1'b0, a0_reg};

    always_comb begin
        state_next = state_reg;
        cur_next = cur_reg;
        pass_next = pass_reg;
        phase_next = phase_reg;
        raddr = cur_reg;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready && s_item.mode == MODE_QUERY && n_eff != '0) begin
                    cur_next = (CW'(last_seg_reg) < n_eff) ? AW'(last_seg_reg) : '0;
                    pass_next = 1'b0;
                    phase_next = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                // fetch cur, or next when phase set
                raddr = phase_reg ? AW'(cur_reg + 1'b1) : cur_reg;
                if (CW'(cur_reg) + 1'b1 >= n_eff && !phase_reg) begin
                    raddr = AW'(n_eff - 1'b1);
                    state_next = S_LAST;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    state_next = S_RD;
                end else if (s_reg >= p0_reg && s_reg < rpos) begin
                    state_next = S_MUL;
                end else begin
                    cur_next = cur_reg + 1'b1;
                    phase_next = 1'b0;
                    state_next = S_RD;
                end
            end
            S_MUL: begin
                // product and length are registered now
                div_start = 1'b1;
                state_next = S_DIV;
            end
            S_LAST: begin
                if (s_reg >= rpos) begin
                    state_next = S_FIN;
                end else if (!pass_reg) begin
                    pass_next = 1'b1;
                    cur_next = '0;
                    phase_next = 1'b0;
                    state_next = S_RD;
                end else begin
                    raddr = '0;
                    cur_next = '0;
                    state_next = S_FIN;
                end
            end
            S_DIV: begin
                if (!div_busy && !div_start) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign lvl = -(LevelW+2)'(attq_reg) - (LevelW+2)'(peak_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            peak_reg <= '0;
            last_seg_reg <= '0;
            m_valid_reg <= 1'b0;
            cur_reg <= '0;
            pass_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            pass_reg <= pass_next;
            phase_reg <= phase_next;
            if (cfg_we) begin
                if (cfg_index == CFG_POINT_COUNT) count_reg <= cfg_wdata[CountW-1:0];
                else peak_reg <= cfg_wdata[PeakW-1:0];
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && s_valid && s_ready
                && s_item.mode == MODE_QUERY && n_eff == '0) begin
                m_valid_reg <= 1'b1;
                m_item_reg <= '0;
            end
            if (state_reg == S_OUT) begin
                m_valid_reg <= 1'b1;
                m_item_reg.envelope_level <= (lvl > (LevelW+2)'(33554431)) ?
                    LevelW'(33554431) : (lvl < -(LevelW+2)'(33554432)) ?
                    LevelW'(-33554432) : LevelW'(lvl);
                m_item_reg.segment_index <= seg_reg;
                last_seg_reg <= seg_reg;
            end
        end
        if (state_reg == S_IDLE) begin
            s_reg <= s_item.sample_position;
            fb_reg <= 1'b0;
        end
        if (state_reg == S_CMP && !phase_reg) begin
            p0_reg <= rpos;
            a0_reg <= ratt;
        end
        if (state_reg == S_CMP && phase_reg) begin
            len_reg <= rpos - p0_reg;
            neg_reg <= ratt < a0_reg;
            seg_reg <= SegW'(cur_reg);
            prod_reg <= NW'(s_reg - p0_reg) * (NW'(mag) << FracBits);
        end
        if (state_reg == S_DIV && !div_busy && !div_start) begin
            attq_reg <= neg_reg ?
                $signed(AQW'(a0_reg) << FracBits) - $signed(AQW'(quot[AttW+FracBits:0]))
              : $signed(AQW'(a0_reg) << FracBits) + $signed(AQW'(quot[AttW+FracBits:0]));
        end
        if (state_reg == S_LAST) begin
            attq_reg <= $signed(AQW'(ratt) << FracBits);
            seg_reg <= SegW'(n_eff - 1'b1);
            // nothing found after the wrap: fall back to the first point
            fb_reg <= pass_reg && (s_reg < rpos);
        end
        if (state_reg == S_FIN && fb_reg) begin
            attq_reg <= $signed(AQW'(ratt) << FracBits);
            seg_reg <= '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;
endmodule

// ===== rtl/ebi_checker.sv =====
`timescale 1ns / 1ps
module ebi_checker import ebi_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item)) else $error("result dropped");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("accept while result pending");
    a_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.mode == MODE_WRITE |=> !m_valid)
        else $error("result from write");
endmodule

bind envelope_breakpoint_interpolator_core ebi_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);

// ===== sim/tb_envelope_breakpoint_interpolator_core.sv =====
`timescale 1ns / 1ps
module tb_envelope_breakpoint_interpolator_core;
    import ebi_pkg::*;

    localparam int  NumPoints   = 256;
    localparam int  ItemTarget  = 1650;
    localparam int  DrainCycles = 2 * NumPoints + 120;
    localparam int  CycleLimit  = 20_000_000;

    typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        cfg_sel;
        int          cfg_val;
        logic [7:0]  pidx;
        logic [31:0] ppos;
        logic [15:0] patt;
        logic [31:0] spos;
        bit          typed;
        int          lvl;
        int          seg;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_index = CFG_POINT_COUNT;
    logic [CfgW-1:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // predictor state
    logic [31:0]        pt_pos [NumPoints];
    logic [15:0]        pt_att [NumPoints];
    logic [CountW-1:0]  count_reg = '0;
    logic signed [PeakW-1:0] peak_reg = '0;
    int                 last_seg = 0;

    out_item_t level_q [$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  queries_sent = 0;
    int  results_seen = 0;
    int  phases = 0;
    longint cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;

    dir_row_t dir_rows [21] = '{
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd0, 1, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'hFFFF_FFFF, 1, 0, 0},
        '{ROW_WRITE, CFG_POINT_COUNT, 0, 8'd0, 32'd1000, 16'h0000, 32'd0, 0, 0, 0},
        '{ROW_WRITE, CFG_POINT_COUNT, 0, 8'd1, 32'd2000, 16'hFFFF, 32'd0, 0, 0, 0},
        '{ROW_WRITE, CFG_POINT_COUNT, 0, 8'd2, 32'd3000, 16'h0000, 32'd0, 0, 0, 0},
        '{ROW_WRITE, CFG_POINT_COUNT, 0, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 0, 0, 0},
        '{ROW_CFG, CFG_POINT_COUNT, 3, 8'd0, 32'd0, 16'd0, 32'd0, 0, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd0, 1, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd1500, 0, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd3000, 1, 0, 2},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd2999, 0, 0, 0},
        '{ROW_CFG, CFG_PEAK, 16777215, 8'd0, 32'd0, 16'd0, 32'd0, 0, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd1000, 1, -16777215, 0},
        '{ROW_CFG, CFG_PEAK, -16777216, 8'd0, 32'd0, 16'd0, 32'd0, 0, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd2000, 1, 256, 1},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'hFFFF_FFFF, 1, 16777216, 2},
        '{ROW_CFG, CFG_POINT_COUNT, 1, 8'd0, 32'd0, 16'd0, 32'd0, 0, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd500, 0, 0, 0},
        '{ROW_CFG, CFG_POINT_COUNT, 2, 8'd0, 32'd0, 16'd0, 32'd0, 0, 0, 0},
        '{ROW_QUERY, CFG_POINT_COUNT, 0, 8'd0, 32'd0, 16'd0, 32'd1999, 0, 0, 0},
        '{ROW_CFG, CFG_PEAK, 0, 8'd0, 32'd0, 16'd0, 32'd0, 0, 0, 0}
    };

    envelope_breakpoint_interpolator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     level_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint segment_att(int k, logic [31:0] s);
        logic [31:0] d;
        logic [31:0] len;
        longint a0;
        longint diff;
        longint unsigned mag;
        longint unsigned q;
        d = s - pt_pos[k];
        len = pt_pos[k+1] - pt_pos[k];
        a0 = longint'(pt_att[k]);
        diff = longint'(pt_att[k+1]) - a0;
        mag = longint'(diff < 0 ? -diff : diff) << FracBitsDef;
        q = (len != 0) ? (64'(d) * mag) / 64'(len) : 0;
        return (diff < 0) ? (a0 << FracBitsDef) - longint'(q)
                          : (a0 << FracBitsDef) + longint'(q);
    endfunction

    // search from the remembered segment, wrap once, then fall back to the first point
    function automatic out_item_t envelope_at(logic [31:0] s);
        int n;
        int start;
        int cur;
        int seg;
        bit hit;
        longint att_q;
        longint lvl;
        out_item_t r;
        n = (count_reg > NumPoints) ? NumPoints : int'(count_reg);
        if (n == 0) return '0;
        start = (last_seg < n) ? last_seg : 0;
        hit = 1'b0;
        seg = 0;
        att_q = 0;
        for (int pass = 0; pass < 2 && !hit; pass++) begin
            cur = start;
            for (int nx = cur + 1; nx < n && !hit; nx++) begin
                if (s >= pt_pos[cur] && s < pt_pos[nx]) begin
                    hit = 1'b1;
                    seg = cur;
                    att_q = segment_att(cur, s);
                end else begin
                    cur = nx;
                end
            end
            if (!hit && s >= pt_pos[n-1]) begin
                hit = 1'b1;
                seg = n - 1;
                att_q = longint'(pt_att[n-1]) << FracBitsDef;
            end
            start = 0;
        end
        if (!hit) begin
            seg = 0;
            att_q = longint'(pt_att[0]) << FracBitsDef;
        end
        lvl = -att_q - longint'(peak_reg);
        if (lvl > 33554431) lvl = 33554431;
        if (lvl < -33554432) lvl = -33554432;
        last_seg = seg;
        r.envelope_level = lvl[LevelW-1:0];
        r.segment_index = seg[SegW-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result level=%0d seg=%0d",
                             m_item.envelope_level, m_item.segment_index);
            end else begin
                want = level_q.pop_front();
                if (m_item.envelope_level !== want.envelope_level ||
                    m_item.segment_index !== want.segment_index) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: level exp %0d got %0d, seg exp %0d got %0d",
                                 want.envelope_level, m_item.envelope_level,
                                 want.segment_index, m_item.segment_index);
                end
            end
        end
    end

    // result side: random back-pressure, one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (500) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // leave valid high when the next item follows at once
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_val);
        out_item_t pred;
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (it.mode == MODE_WRITE) begin
            pt_pos[it.point_index] = it.point_position;
            pt_att[it.point_index] = it.point_attenuation;
        end else begin
            queries_sent++;
            pred = envelope_at(it.sample_position);
            level_q.push_back(typed ? typed_val : pred);
        end
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic drain_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (level_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(logic sel, int val);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val[CfgW-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (sel == CFG_POINT_COUNT) count_reg = val[CountW-1:0];
        else peak_reg = val[PeakW-1:0];
        @(posedge aclk);
    endtask

    function automatic in_item_t write_item(int idx, logic [31:0] pos, logic [15:0] att);
        in_item_t it;
        it = '0;
        it.mode = MODE_WRITE;
        it.point_index = idx[7:0];
        it.point_position = pos;
        it.point_attenuation = att;
        it.sample_position = $urandom;
        return it;
    endfunction

    function automatic in_item_t query_item(logic [31:0] s);
        in_item_t it;
        it = '0;
        it.mode = MODE_QUERY;
        it.point_index = 8'($urandom);
        it.point_position = $urandom;
        it.point_attenuation = 16'($urandom);
        it.sample_position = s;
        return it;
    endfunction

    // load entries 0..n-1 with rising positions; large gaps may wrap out of order
    task automatic load_sorted(int n);
        logic [31:0] pos;
        pos = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1000));
        for (int k = 0; k < n; k++) begin
            send_item(write_item(k, pos, 16'($urandom)), 1'b0, '0);
            case ($urandom_range(0, 3))
                0: pos += $urandom_range(0, 3);
                1: pos += $urandom_range(1, 64);
                2: pos += $urandom_range(1, 1 << 20);
                default: pos += $urandom_range(1, 1 << 24);
            endcase
        end
    endtask

    function automatic logic [31:0] pick_position(int n);
        int k;
        k = (n > 0) ? $urandom_range(0, n - 1) : 0;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h0;
            2: return 32'hFFFF_FFFF;
            3: return pt_pos[k] - 1;
            4: return pt_pos[k];
            default: return pt_pos[k] + $urandom_range(0, 40);
        endcase
    endfunction

    initial begin
        out_item_t typed_val;
        int n;
        int peak;
        int len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            typed_val.envelope_level = dir_rows[i].lvl[LevelW-1:0];
            typed_val.segment_index = dir_rows[i].seg[SegW-1:0];
            case (dir_rows[i].kind)
                ROW_WRITE: send_item(write_item(dir_rows[i].pidx, dir_rows[i].ppos,
                                                dir_rows[i].patt), 1'b0, '0);
                ROW_QUERY: send_item(query_item(dir_rows[i].spos), dir_rows[i].typed,
                                     typed_val);
                default: begin
                    drain_idle();
                    write_reg(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
                end
            endcase
        end

        // fill the whole table once so that any point count reads written entries
        load_sorted(NumPoints);

        while (items_sent < ItemTarget) begin
            phases++;
            if (phases == 2) n = NumPoints;
            else case ($urandom_range(0, 9))
                0: n = 0;
                1: n = 1;
                2: n = 2;
                default: n = $urandom_range(3, 24);
            endcase
            case ($urandom_range(0, 5))
                0: peak = 16777215;
                1: peak = -16777216;
                2: peak = 0;
                default: peak = $urandom_range(0, 33554431) - 16777216;
            endcase
            drain_idle();
            write_reg(CFG_POINT_COUNT, n);
            write_reg(CFG_PEAK, peak);
            if (n != NumPoints && $urandom_range(0, 4) != 0) load_sorted(n);
            len = (n == NumPoints) ? 20 : 40;
            for (int j = 0; j < len; j++) begin
                if (items_sent > ItemTarget - 150) quiet = 1'b1;
                if (phases == 4 && j == 5) hold_req = 1'b1;
                if ($urandom_range(0, 6) == 0)
                    send_item(write_item($urandom_range(0, 255), $urandom, 16'($urandom)),
                              1'b0, '0);
                else
                    send_item(query_item(pick_position(n)), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        $display("sent %0d items (%0d queries) over %0d config phases, checked %0d results",
                 items_sent, queries_sent, phases, results_seen);
        $display("point counts 0..256, peak extremes, back-pressure and gaps; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && level_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ebi_pkg.sv
rtl/ebi_div.sv
rtl/ebi_table.sv
rtl/envelope_breakpoint_interpolator_core.sv
rtl/ebi_checker.sv
sim/tb_envelope_breakpoint_interpolator_core.sv
